FILE: design/nlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlf_pkg
// Shared constants, codes and handshake types of the nonlinear ladder filter.
// ----------------------------------------------------------------------------
package nlf_pkg;

    localparam int SAMPLE_WIDTH_DEF     = 16;
    localparam int STATE_WIDTH_DEF      = 24;
    localparam int TANH_TABLE_DEPTH_DEF = 1024;

    // Coefficient registers and the digit-serial multiplier.
    localparam int COEF_W  = 16;
    localparam int DIGIT_W = 4;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [COEF_W-1:0] CUTOFF_RESET   = 16'd8041;
    localparam logic [COEF_W-1:0] FEEDBACK_RESET = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF   = 2'd0,
        CFG_FEEDBACK = 2'd1,
        CFG_MODE     = 2'd2,
        CFG_SPARE    = 2'd3
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LP24 = 2'd0,
        MODE_LP12 = 2'd1,
        MODE_BP   = 2'd2,
        MODE_HP   = 2'd3
    } filter_mode_t;

    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

endpackage

FILE: design/nlf_tanh_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlf_tanh_rom
// Constant tanh table over [0, 8) with a registered read port.
// ----------------------------------------------------------------------------
module nlf_tanh_rom #(
    parameter int STATE_WIDTH      = nlf_pkg::STATE_WIDTH_DEF,
    parameter int TANH_TABLE_DEPTH = nlf_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic [$clog2(TANH_TABLE_DEPTH)-1:0] rd_addr,
    output logic [STATE_WIDTH-2:0]              rd_data
);

    localparam int FRAC = STATE_WIDTH - 1;

    typedef logic [FRAC-1:0] tab_t [TANH_TABLE_DEPTH];

    // Restoring long division; only used while the table is built.
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned dvs);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            rem = {rem[62:0], num[bit_i]};
            if (rem >= dvs) begin
                rem        = rem - dvs;
                quo[bit_i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry i is tanh(8*i/DEPTH): exp by series and squaring, then (1-e)/(1+e).
    function automatic tab_t build_tab();
        tab_t              tab;
        longint unsigned   t, sum, term, e, den, r31, r, one31;
        for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
            one31 = 64'd1 << 31;
            t     = (longint'(i) << 29) / TANH_TABLE_DEPTH;
            sum   = one31;
            term  = one31;
            for (int n = 1; n <= 12; n++) begin
                term = udiv((term * t) >> 31, 64'(n));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            e = sum;
            for (int n = 0; n < 6; n++) begin
                e = (e * e + (one31 >> 1)) >> 31;
            end
            den = one31 + e;
            r31 = udiv(((one31 - e) << 31) + (den >> 1), den);
            if (FRAC >= 31) begin
                r = r31 << (FRAC - 31);
            end else begin
                r = (r31 + (64'd1 << (30 - FRAC))) >> (31 - FRAC);
            end
            if (r > (64'd1 << FRAC) - 1) begin
                r = (64'd1 << FRAC) - 1;
            end
            tab[i] = r[FRAC-1:0];
        end
        return tab;
    endfunction

    localparam tab_t TAB = build_tab();

    always_ff @(posedge aclk) begin
        rd_data <= TAB[rd_addr];
    end

endmodule

FILE: design/nlf_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlf_serial_mul
// Digit-serial signed by unsigned multiplier, one coefficient digit a cycle.
// ----------------------------------------------------------------------------
module nlf_serial_mul #(
    parameter int A_WIDTH = nlf_pkg::STATE_WIDTH_DEF + 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  nlf_pkg::mul_ctl_t                     ctl,
    input  logic signed [A_WIDTH-1:0]             a,
    input  logic [nlf_pkg::COEF_W-1:0]            b,
    output nlf_pkg::mul_sts_t                     sts,
    output logic signed [A_WIDTH+nlf_pkg::COEF_W:0] product
);

    localparam int PW     = A_WIDTH + nlf_pkg::COEF_W + 1;
    localparam int NDIG   = nlf_pkg::COEF_W / nlf_pkg::DIGIT_W;
    localparam int CNT_W  = $clog2(NDIG);
    localparam int DW     = nlf_pkg::DIGIT_W;

    logic signed [PW-1:0]              a_reg;
    logic [nlf_pkg::COEF_W-1:0]        b_reg;
    logic signed [PW-1:0]              acc_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic signed [PW-1:0]              partial;

    assign partial = PW'(a_reg * $signed({1'b0, b_reg[DW-1:0]}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NDIG - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            a_reg   <= PW'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + partial;
            a_reg   <= a_reg <<< DW;
            b_reg   <= b_reg >> DW;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;

endmodule

FILE: design/nonlinear_ladder_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonlinear_ladder_filter
// Four-pole ladder filter with tanh saturation and selectable response.
// ----------------------------------------------------------------------------
// One signed sample enters on the s_ stream and one filtered sample leaves
// on the m_ stream. Coefficients and the response mode are written through
// the cfg_ channel, which is always ready; write it only while idle.
// Each sample runs a shared multiplier that walks the 16-bit coefficients
// four bits a cycle, five times per sample for the feedback and four
// stage products (six in highpass mode), and five tanh lookups that each
// address the registered table and then read it. A new request is taken
// in the cycle after the result is registered.
// A new sample is accepted only when the previous one has been computed;
// the finished sample sits in an output register, so the next request is
// taken while the receiver still stalls on it. Should it still stall when
// the next result is ready, the core waits. Reset clears the four stage
// values, the registers to their defaults and empties the output.
// ----------------------------------------------------------------------------
module nonlinear_ladder_filter #(
    parameter int SAMPLE_WIDTH     = nlf_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH      = nlf_pkg::STATE_WIDTH_DEF,
    parameter int TANH_TABLE_DEPTH = nlf_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,  // sample_in
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata,  // sample_out
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [nlf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [nlf_pkg::COEF_W-1:0]             cfg_data
);

    localparam int TDW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SW    = STATE_WIDTH;
    localparam int FRAC  = SW - 1;
    localparam int OPW   = SW + 1;
    localparam int PW    = OPW + nlf_pkg::COEF_W + 1;
    localparam int UW    = SW + 4;
    localparam int LOG2D = $clog2(TANH_TABLE_DEPTH);
    localparam int SHI   = FRAC + 3 - LOG2D;
    localparam int IW    = UW + 1 - SHI;
    localparam int SH    = STATE_WIDTH - SAMPLE_WIDTH;
    localparam int CW    = UW + 1 + ((SH < 0) ? -SH : 0);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MULK  = 9'b000000010,
        S_LOOKU = 9'b000000100,
        S_READU = 9'b000001000,
        S_LOOK  = 9'b000010000,
        S_READ  = 9'b000100000,
        S_MULG  = 9'b001000000,
        S_MULH  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t                       state_reg;
    logic [nlf_pkg::COEF_W-1:0]   cutoff_reg;
    logic [nlf_pkg::COEF_W-1:0]   feedback_reg;
    nlf_pkg::filter_mode_t        mode_reg;
    logic signed [SW-1:0]         stage_reg [4];
    logic [1:0]                   pole_reg;
    logic signed [SW:0]           x_reg;
    logic signed [UW-1:0]         val_reg;
    logic signed [UW-1:0]         hp_reg;
    logic                         neg_reg;
    logic                         m_valid_reg;
    logic [SAMPLE_WIDTH-1:0]      m_data_reg;

    // ---- input sample to state format -------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [SW:0]             x_conv;
    assign smp = $signed(s_tdata[SAMPLE_WIDTH-1:0]);

    generate
        if (SH >= 0) begin : g_in_up
            assign x_conv = (SW + 1)'(smp) <<< SH;
        end else begin : g_in_down
            logic signed [SAMPLE_WIDTH:0] smp_rnd;
            assign smp_rnd = (SAMPLE_WIDTH + 1)'(smp) + (SAMPLE_WIDTH + 1)'(1 << (-SH - 1));
            assign x_conv  = (SW + 1)'(smp_rnd >>> (-SH));
        end
    endgenerate

    // ---- tanh lookup of val_reg -----------------------------------------
    localparam logic [UW:0] HALF = (UW + 1)'(1) << (SHI - 1);
    logic             val_neg;
    logic [UW-1:0]    mag;
    logic [UW:0]      mag_rnd;
    logic [IW-1:0]    idx_wide;
    logic [LOG2D-1:0] rom_addr;
    logic [FRAC-1:0]  rom_data;
    logic signed [SW-1:0] tanh_val;

    assign val_neg  = val_reg[UW-1];
    assign mag      = val_neg ? UW'(-val_reg) : UW'(val_reg);
    assign mag_rnd  = {1'b0, mag} + HALF;
    assign idx_wide = mag_rnd[UW:SHI];
    assign rom_addr = (idx_wide >= IW'(TANH_TABLE_DEPTH)) ? '1 : idx_wide[LOG2D-1:0];
    assign tanh_val = neg_reg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

    nlf_tanh_rom #(
        .STATE_WIDTH      (STATE_WIDTH),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    // ---- shared multiplier ---------------------------------------------
    nlf_pkg::mul_ctl_t            mul_ctl;
    nlf_pkg::mul_sts_t            mul_sts;
    logic signed [OPW-1:0]        mul_a;
    logic [nlf_pkg::COEF_W-1:0]   mul_b;
    logic signed [PW-1:0]         product;
    logic signed [PW-1:0]         prod_r13;
    logic signed [PW-1:0]         prod_r16;
    logic signed [UW-1:0]         k_term;
    logic signed [SW:0]           y_new;
    logic signed [SW:0]           diff;
    logic                         accept;
    logic                         last_pole;

    nlf_serial_mul #(
        .A_WIDTH (OPW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .b       (mul_b),
        .sts     (mul_sts),
        .product (product)
    );

    assign prod_r13  = (product + PW'(1 << 12)) >>> 13;
    assign prod_r16  = (product + PW'(1 << 15)) >>> 16;
    assign k_term    = UW'(prod_r13);
    assign y_new     = (SW + 1)'(stage_reg[pole_reg]) + (SW + 1)'(prod_r16);
    assign diff      = (SW + 1)'(tanh_val) - (SW + 1)'(stage_reg[pole_reg]);
    assign accept    = s_tvalid && s_tready;
    assign last_pole = (pole_reg == 2'd3);

    always_comb begin
        mul_ctl.start = 1'b0;
        mul_a         = OPW'(stage_reg[3]);
        mul_b         = feedback_reg;
        case (state_reg)
            S_IDLE: begin
                mul_ctl.start = accept;
            end
            S_READ: begin
                mul_ctl.start = 1'b1;
                mul_a         = diff;
                mul_b         = cutoff_reg;
            end
            S_MULG: begin
                mul_ctl.start = mul_sts.done && last_pole && (mode_reg == nlf_pkg::MODE_HP);
                mul_a         = OPW'($signed(y_new[SW-1:0]));
            end
            default: begin
                mul_ctl.start = 1'b0;
            end
        endcase
    end

    // ---- result selection and output format ------------------------------
    logic signed [UW-1:0]           res;
    logic signed [CW-1:0]           res_conv;
    logic [SAMPLE_WIDTH-1:0]        res_sat;
    localparam logic signed [CW-1:0] SAT_HI = CW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [CW-1:0] SAT_LO = CW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    always_comb begin
        case (mode_reg)
            nlf_pkg::MODE_LP12: res = UW'(stage_reg[1]);
            nlf_pkg::MODE_BP:   res = UW'(stage_reg[1]) - UW'(stage_reg[3]);
            nlf_pkg::MODE_HP:   res = UW'(x_reg) - UW'(stage_reg[1]) - hp_reg;
            default:            res = UW'(stage_reg[3]);
        endcase
    end

    generate
        if (SH > 0) begin : g_out_down
            logic signed [UW:0] res_rnd;
            assign res_rnd  = (UW + 1)'(res) + (UW + 1)'(1 << (SH - 1));
            assign res_conv = CW'(res_rnd >>> SH);
        end else begin : g_out_up
            assign res_conv = CW'(res) <<< (-SH);
        end
    endgenerate

    always_comb begin
        if (res_conv > SAT_HI) begin
            res_sat = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (res_conv < SAT_LO) begin
            res_sat = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            res_sat = res_conv[SAMPLE_WIDTH-1:0];
        end
    end

    // ---- configuration ---------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg   <= nlf_pkg::CUTOFF_RESET;
            feedback_reg <= nlf_pkg::FEEDBACK_RESET;
            mode_reg     <= nlf_pkg::MODE_LP24;
        end else if (cfg_valid) begin
            case (cfg_index)
                nlf_pkg::CFG_CUTOFF:   cutoff_reg   <= cfg_data;
                nlf_pkg::CFG_FEEDBACK: feedback_reg <= cfg_data;
                nlf_pkg::CFG_MODE:
                    mode_reg <= nlf_pkg::filter_mode_t'(cfg_data[nlf_pkg::MODE_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---- sequencer -------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pole_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                stage_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        x_reg     <= x_conv;
                        state_reg <= S_MULK;
                    end
                end
                S_MULK: begin
                    if (mul_sts.done) begin
                        val_reg   <= UW'(x_reg) - k_term;
                        state_reg <= S_LOOKU;
                    end
                end
                S_LOOKU: begin
                    neg_reg   <= val_neg;
                    state_reg <= S_READU;
                end
                S_READU: begin
                    val_reg   <= UW'(tanh_val);
                    state_reg <= S_LOOK;
                end
                S_LOOK: begin
                    neg_reg   <= val_neg;
                    state_reg <= S_READ;
                end
                S_READ: begin
                    state_reg <= S_MULG;
                end
                S_MULG: begin
                    if (mul_sts.done) begin
                        stage_reg[pole_reg] <= y_new[SW-1:0];
                        val_reg             <= UW'($signed(y_new[SW-1:0]));
                        pole_reg            <= pole_reg + 2'd1;
                        if (!last_pole) begin
                            state_reg <= S_LOOK;
                        end else if (mode_reg == nlf_pkg::MODE_HP) begin
                            state_reg <= S_MULH;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_MULH: begin
                    if (mul_sts.done) begin
                        hp_reg    <= k_term;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_sat;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = TDW'(m_data_reg);

endmodule
